// ----- rtl/icc_pkg.sv -----
package icc_pkg;

  // number of implemented irq source bits (2 to 32)
  localparam int NUM_IRQ_SOURCES = 32;

  // word and field widths
  localparam int WORD_W = 32;
  localparam int OFF_W  = 8;
  localparam int SRC_W  = 5;

  // soft register drives this pending bit
  localparam int SOFT_BIT_IDX = 1;

  // request kinds
  typedef enum logic [2:0] {
    MODE_IRQ_SRC   = 3'd0,
    MODE_FIQ_SRC   = 3'd1,
    MODE_IRQ_READ  = 3'd2,
    MODE_IRQ_WRITE = 3'd3,
    MODE_FIQ_READ  = 3'd4,
    MODE_FIQ_WRITE = 3'd5
  } mode_t;

  // transfer status
  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_UNPERMITTED = 2'd1,
    ST_UNMAPPED    = 2'd2
  } status_t;

  // register word offsets within a bank
  localparam logic [OFF_W-1:0] OFF_STATUS     = 8'd0;
  localparam logic [OFF_W-1:0] OFF_RAW_STATUS = 8'd1;
  localparam logic [OFF_W-1:0] OFF_ENABLE_SET = 8'd2;
  localparam logic [OFF_W-1:0] OFF_ENABLE_CLR = 8'd3;
  localparam logic [OFF_W-1:0] OFF_SOFT       = 8'd4;

  // read offset 2 returns the enable word
  localparam logic [OFF_W-1:0] OFF_ENABLE     = OFF_ENABLE_SET;

  typedef struct packed {
    mode_t             mode;
    logic [OFF_W-1:0]  reg_offset;
    logic [WORD_W-1:0] write_data;
    logic              source_level;
    logic [SRC_W-1:0]  source_bit;
  } req_t;

  typedef struct packed {
    logic [WORD_W-1:0] read_data;
    status_t           bus_status;
    logic              irq_line;
    logic              fiq_line;
  } rsp_t;

endpackage

// ----- rtl/icc_in_reg.sv -----
module icc_in_reg import icc_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  req_valid,
  output logic  req_ready,
  input  req_t  req,
  input  logic  advance,
  output logic  stage_valid,
  output req_t  stage
);

  // stage takes a new transfer when empty or when its item moves on
  assign req_ready = !stage_valid || advance;

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (req_ready) begin
      stage_valid <= req_valid;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      stage <= req;
    end
  end

endmodule

// ----- rtl/icc_bank.sv -----
module icc_bank import icc_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic fire,
  input  req_t item,
  output rsp_t result
);

  logic [NUM_IRQ_SOURCES-1:0] irq_raw;
  logic [NUM_IRQ_SOURCES-1:0] irq_enable;
  logic                       fiq_raw;
  logic [WORD_W-1:0]          fiq_enable;

  logic [NUM_IRQ_SOURCES-1:0] irq_raw_next;
  logic [NUM_IRQ_SOURCES-1:0] irq_enable_next;
  logic                       fiq_raw_next;
  logic [WORD_W-1:0]          fiq_enable_next;
  logic [WORD_W-1:0]          rd;
  status_t                    st;
  logic                       fiq_status;

  assign fiq_status = fiq_raw && (fiq_enable != '0);

  // decode and next state
  always_comb begin
    irq_raw_next     = irq_raw;
    irq_enable_next  = irq_enable;
    fiq_raw_next     = fiq_raw;
    fiq_enable_next  = fiq_enable;
    rd               = '0;
    st               = ST_OK;
    case (item.mode)
      MODE_IRQ_SRC: begin
        // out-of-range source numbers match no bit
        for (int i = 0; i < NUM_IRQ_SOURCES; i++) begin
          if (item.source_bit == SRC_W'(i)) begin
            irq_raw_next[i] = item.source_level;
          end
        end
      end
      MODE_FIQ_SRC: begin
        fiq_raw_next = item.source_level;
      end
      MODE_IRQ_READ: begin
        if (item.reg_offset == OFF_STATUS) begin
          rd = WORD_W'(irq_raw & irq_enable);
        end else if (item.reg_offset == OFF_RAW_STATUS) begin
          rd = WORD_W'(irq_raw);
        end else if (item.reg_offset == OFF_ENABLE) begin
          rd = WORD_W'(irq_enable);
        end else if (item.reg_offset inside {OFF_ENABLE_CLR, OFF_SOFT}) begin
          st = ST_UNPERMITTED;
        end else begin
          st = ST_UNMAPPED;
        end
      end
      MODE_IRQ_WRITE: begin
        if (item.reg_offset == OFF_ENABLE_SET) begin
          irq_enable_next = irq_enable | item.write_data[NUM_IRQ_SOURCES-1:0];
        end else if (item.reg_offset == OFF_ENABLE_CLR) begin
          irq_enable_next = irq_enable & ~item.write_data[NUM_IRQ_SOURCES-1:0];
        end else if (item.reg_offset == OFF_SOFT) begin
          irq_raw_next[SOFT_BIT_IDX] = item.write_data[SOFT_BIT_IDX];
        end else if (item.reg_offset inside {OFF_STATUS, OFF_RAW_STATUS}) begin
          st = ST_UNPERMITTED;
        end else begin
          st = ST_UNMAPPED;
        end
      end
      MODE_FIQ_READ: begin
        if (item.reg_offset == OFF_STATUS) begin
          rd = WORD_W'(fiq_status);
        end else if (item.reg_offset == OFF_RAW_STATUS) begin
          rd = WORD_W'(fiq_raw);
        end else if (item.reg_offset == OFF_ENABLE) begin
          rd = fiq_enable;
        end else if (item.reg_offset == OFF_ENABLE_CLR) begin
          st = ST_UNPERMITTED;
        end else begin
          st = ST_UNMAPPED;
        end
      end
      MODE_FIQ_WRITE: begin
        if (item.reg_offset == OFF_ENABLE_SET) begin
          fiq_enable_next = fiq_enable | item.write_data;
        end else if (item.reg_offset == OFF_ENABLE_CLR) begin
          fiq_enable_next = fiq_enable & ~item.write_data;
        end else if (item.reg_offset inside {OFF_STATUS, OFF_RAW_STATUS}) begin
          st = ST_UNPERMITTED;
        end else begin
          st = ST_UNMAPPED;
        end
      end
      default: begin
      end
    endcase
  end

  // result shows the lines after the update
  always_comb begin
    result.read_data  = rd;
    result.bus_status = st;
    result.irq_line   = |(irq_raw_next & irq_enable_next);
    result.fiq_line   = fiq_raw_next && (fiq_enable_next != '0);
  end

  // bank state
  always_ff @(posedge clk) begin
    if (rst) begin
      irq_raw     <= '0;
      irq_enable  <= '0;
      fiq_raw     <= 1'b0;
      fiq_enable  <= '0;
    end else if (fire) begin
      irq_raw     <= irq_raw_next;
      irq_enable  <= irq_enable_next;
      fiq_raw     <= fiq_raw_next;
      fiq_enable  <= fiq_enable_next;
    end
  end

`ifndef SYNTHESIS
  // a failed access leaves every register alone
  a_fail_no_change: assert property (@(posedge clk) disable iff (rst)
    fire && (result.bus_status != ST_OK)
    |=> $stable(irq_raw) && $stable(irq_enable) && $stable(fiq_raw)
        && $stable(fiq_enable))
    else $error("failed access changed bank state");

  // state moves only when an item is processed
  a_idle_hold: assert property (@(posedge clk) disable iff (rst)
    !fire |=> $stable(irq_raw) && $stable(irq_enable) && $stable(fiq_raw)
              && $stable(fiq_enable))
    else $error("bank state changed without an item");

  // reported lines agree with the state just written
  a_lines_match: assert property (@(posedge clk) disable iff (rst)
    fire |=> ($past(result.irq_line) == |(irq_raw & irq_enable))
             && ($past(result.fiq_line) == fiq_status))
    else $error("interrupt lines disagree with bank state");
`endif

endmodule

// ----- rtl/icc_out_reg.sv -----
module icc_out_reg import icc_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic load,
  input  rsp_t result,
  output logic can_load,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  // room when empty or when the held result leaves this cycle
  assign can_load = !rsp_valid || rsp_ready;

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (can_load) begin
      rsp_valid <= load;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (load) begin
      rsp <= result;
    end
  end

endmodule

// ----- rtl/irq_fiq_interrupt_controller_core.sv -----
// channel   signals                        direction  payload
// request   req_valid, req_ready, req      into block req_t
// response  rsp_valid, rsp_ready, rsp      out of     rsp_t
//
// one request per cycle unless the response stalls; responses are registered
// decode and register update happen between input and result registers
// rst is synchronous and clears the bank registers and both valid flags
// a stalled response holds the request stage; req_ready drops only when both are full
module irq_fiq_interrupt_controller_core import icc_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  req_t  stage;
  rsp_t  result;
  logic  stage_valid;
  logic  advance;
  logic  can_load;

  // item in the stage is processed when the result register has room
  assign advance = stage_valid && can_load;

  icc_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_ready  (req_ready),
    .req        (req),
    .advance    (advance),
    .stage_valid(stage_valid),
    .stage      (stage)
  );

  icc_bank u_bank (
    .clk   (clk),
    .rst   (rst),
    .fire  (advance),
    .item  (stage),
    .result(result)
  );

  icc_out_reg u_out_reg (
    .clk      (clk),
    .rst      (rst),
    .load     (advance),
    .result   (result),
    .can_load (can_load),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp      (rsp)
  );

`ifndef SYNTHESIS
  // backpressure only when both stages hold an item and the output stalls
  a_ready_cause: assert property (@(posedge clk) disable iff (rst)
    !req_ready |-> stage_valid && rsp_valid && !rsp_ready)
    else $error("request stalled without a full pipe");

  // a processed item always shows up as a response next cycle
  a_item_delivered: assert property (@(posedge clk) disable iff (rst)
    advance |=> rsp_valid)
    else $error("processed item produced no response");

  // unsuccessful accesses return zero data
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.bus_status != ST_OK) |-> rsp.read_data == '0)
    else $error("failed access returned data");
`endif

endmodule
